[rtl/ntcbt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ntcbt_pkg;

  localparam int ADC_BITS_DEF = 10;
  localparam int FRAC_BITS    = 24;
  localparam int QUO_BITS     = 21;
  localparam int DEN_W        = 48;

  localparam logic [31:0] LN2_Q32  = 32'd2977044472;
  localparam logic [27:0] DIV5_K   = 28'd214748365;
  localparam logic [20:0] TK_CAP   = 21'd2000000;

  localparam logic [15:0] BETA_RST = 16'd4250;
  localparam logic [15:0] T0_RST   = 16'd29815;
  localparam logic [23:0] R0_RST   = 24'd100000;
  localparam logic [23:0] RBAL_RST = 24'd100000;

  typedef enum logic [2:0] {
    CFG_BETA = 3'd0,
    CFG_T0   = 3'd1,
    CFG_R0   = 3'd2,
    CFG_RBAL = 3'd3,
    CFG_UNIT = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    UNIT_K = 2'd0,
    UNIT_C = 2'd1,
    UNIT_F = 2'd2
  } unit_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  typedef struct packed {
    logic vld;
    logic cfg_bad;
    logic zero;
    logic np;
    logic ovf;
  } sband_t;

  typedef struct packed {
    logic [4:0]  k;
    logic [30:0] m;
    logic [23:0] frac;
  } log_lane_t;

  typedef struct packed {
    logic [47:0] den;
    logic [47:0] rem;
    logic [20:0] low;
    logic [20:0] q;
  } div_lane_t;

  function automatic log_lane_t log_norm(input logic [23:0] x);
    log_lane_t   r;
    logic [4:0]  k;
    k = '0;
    for (int i = 1; i < 24; i++) begin
      if (x[i]) k = 5'(i);
    end
    r.k    = k;
    r.m    = {7'd0, x} << (5'd30 - k);
    r.frac = '0;
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/ntcbt_log_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module ntcbt_log_cell (
  input  wire                          clk,
  input  wire                          rst_n,
  input  ntcbt_pkg::sband_t            sb_i,
  input  ntcbt_pkg::log_lane_t [3:0]   lane_i,
  output ntcbt_pkg::sband_t            sb_o,
  output ntcbt_pkg::log_lane_t [3:0]   lane_o
);

  ntcbt_pkg::sband_t          sb_r;
  ntcbt_pkg::log_lane_t [3:0] lane_r;
  ntcbt_pkg::log_lane_t [3:0] lane_nxt;
  logic [61:0]                sq [4];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      sq[j]          = 62'(lane_i[j].m) * 62'(lane_i[j].m);
      lane_nxt[j].k  = lane_i[j].k;
      if (sq[j][61]) begin
        lane_nxt[j].m    = sq[j][61:31];
        lane_nxt[j].frac = {lane_i[j].frac[22:0], 1'b1};
      end else begin
        lane_nxt[j].m    = sq[j][60:30];
        lane_nxt[j].frac = {lane_i[j].frac[22:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_r <= '0;
    end else begin
      sb_r <= sb_i;
    end
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
  end

  assign sb_o   = sb_r;
  assign lane_o = lane_r;

endmodule

`default_nettype wire

[rtl/ntcbt_div_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module ntcbt_div_cell (
  input  wire                     clk,
  input  wire                     rst_n,
  input  ntcbt_pkg::sband_t       sb_i,
  input  ntcbt_pkg::div_lane_t    lane_i,
  output ntcbt_pkg::sband_t       sb_o,
  output ntcbt_pkg::div_lane_t    lane_o
);

  ntcbt_pkg::sband_t    sb_r;
  ntcbt_pkg::div_lane_t lane_r;
  ntcbt_pkg::div_lane_t lane_nxt;
  logic [48:0]          trial;

  always_comb begin
    trial        = {lane_i.rem, lane_i.low[20]};
    lane_nxt.den = lane_i.den;
    lane_nxt.low = {lane_i.low[19:0], 1'b0};
    if (trial >= {1'b0, lane_i.den}) begin
      lane_nxt.rem = 48'(trial - {1'b0, lane_i.den});
      lane_nxt.q   = {lane_i.q[19:0], 1'b1};
    end else begin
      lane_nxt.rem = trial[47:0];
      lane_nxt.q   = {lane_i.q[19:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_r <= '0;
    end else begin
      sb_r <= sb_i;
    end
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
  end

  assign sb_o   = sb_r;
  assign lane_o = lane_r;

endmodule

`default_nettype wire

[rtl/ntc_beta_temperature.sv]
`timescale 1ns / 1ps
`default_nettype none

// A request is taken in every cycle; busy stays low and the throughput is one sample per cycle.
// The result strobe follows the request through 24 log squaring cells, 21 divider cells
// and ten further pipeline stages.
// The receiver cannot stall; each result is shown for one cycle only.
// Synchronous reset empties the pipeline and loads the default configuration.

module ntc_beta_temperature #(
  parameter int ADC_BITS = ntcbt_pkg::ADC_BITS_DEF
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  output logic                       busy,
  input  wire  [ADC_BITS-1:0]        in_adc_sample,
  output logic                       out_valid,
  output logic signed [17:0]         out_temperature_centi,
  output logic [1:0]                 out_status,
  input  wire                        cfg_we,
  input  wire  [2:0]                 cfg_index,
  input  wire  [23:0]                cfg_wdata
);

  localparam int LAT = 10 + ntcbt_pkg::FRAC_BITS + ntcbt_pkg::QUO_BITS;

  logic [15:0] beta_r, t0_r;
  logic [23:0] r0_r, rbal_r;
  logic [1:0]  unit_r;
  logic [22:0] b100_r;
  logic [31:0] tb_r;
  logic [38:0] numc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_r <= ntcbt_pkg::BETA_RST;
      t0_r   <= ntcbt_pkg::T0_RST;
      r0_r   <= ntcbt_pkg::R0_RST;
      rbal_r <= ntcbt_pkg::RBAL_RST;
      unit_r <= ntcbt_pkg::UNIT_C;
    end else if (cfg_we) begin
      unique case (ntcbt_pkg::cfg_idx_t'(cfg_index))
        ntcbt_pkg::CFG_BETA: beta_r <= cfg_wdata[15:0];
        ntcbt_pkg::CFG_T0:   t0_r   <= cfg_wdata[15:0];
        ntcbt_pkg::CFG_R0:   r0_r   <= cfg_wdata;
        ntcbt_pkg::CFG_RBAL: rbal_r <= cfg_wdata;
        ntcbt_pkg::CFG_UNIT: unit_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    b100_r <= 23'(beta_r) * 23'd100;
    tb_r   <= 32'(t0_r) * 32'(beta_r);
    numc_r <= 39'(tb_r) * 39'd100;
  end

  assign busy = 1'b0;

  // Input register.
  ntcbt_pkg::sband_t     s0_sb_r;
  logic [ADC_BITS-1:0]   s0_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_sb_r <= '0;
    end else begin
      s0_sb_r.vld     <= start && !busy;
      s0_sb_r.cfg_bad <= (beta_r == '0) || (t0_r == '0) || (r0_r == '0) || (rbal_r == '0);
      s0_sb_r.zero    <= (in_adc_sample == '0);
      s0_sb_r.np      <= 1'b0;
      s0_sb_r.ovf     <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    s0_s_r <= in_adc_sample;
  end

  // Normalisation of the four log arguments.
  logic [ADC_BITS:0]                fms;
  ntcbt_pkg::log_lane_t [3:0]       lg_lane [ntcbt_pkg::FRAC_BITS+1];
  ntcbt_pkg::sband_t                lg_sb   [ntcbt_pkg::FRAC_BITS+1];

  assign fms = {1'b1, {ADC_BITS{1'b0}}} - {1'b0, s0_s_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lg_sb[0] <= '0;
    end else begin
      lg_sb[0] <= s0_sb_r;
    end
  end

  always_ff @(posedge clk) begin
    lg_lane[0][0] <= ntcbt_pkg::log_norm(rbal_r);
    lg_lane[0][1] <= ntcbt_pkg::log_norm(24'(s0_s_r));
    lg_lane[0][2] <= ntcbt_pkg::log_norm(24'(fms));
    lg_lane[0][3] <= ntcbt_pkg::log_norm(r0_r);
  end

  for (genvar g = 0; g < ntcbt_pkg::FRAC_BITS; g++) begin : g_log
    ntcbt_log_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .sb_i   (lg_sb[g]),
      .lane_i (lg_lane[g]),
      .sb_o   (lg_sb[g+1]),
      .lane_o (lg_lane[g+1])
    );
  end

  // Log sum, scaling to natural log, denominator, dividend.
  ntcbt_pkg::sband_t   d_sb_r, q_sb_r, e_sb_r, v_sb_r;
  logic signed [30:0]  d_r, lnq_r;
  logic [47:0]         den_r, vden_r;
  logic [63:0]         dvd_r;
  logic [28:0]         lb, ls, lf, lr;
  logic                neg;
  logic [29:0]         mag, mag2;
  logic [61:0]         prodl;
  logic [62:0]         rnd;
  logic signed [47:0]  prodt;
  logic signed [48:0]  den49;

  ntcbt_pkg::log_lane_t [3:0] lg_end;
  assign lg_end = lg_lane[ntcbt_pkg::FRAC_BITS];
  assign lb = {lg_end[0].k, lg_end[0].frac};
  assign ls = {lg_end[1].k, lg_end[1].frac};
  assign lf = {lg_end[2].k, lg_end[2].frac};
  assign lr = {lg_end[3].k, lg_end[3].frac};

  assign neg   = d_r[30];
  assign mag   = neg ? 30'(-d_r) : d_r[29:0];
  assign prodl = 62'(mag) * 62'(ntcbt_pkg::LN2_Q32);
  assign rnd   = {1'b0, prodl} + 63'h8000_0000;
  assign mag2  = rnd[61:32];
  assign prodt = 48'($signed({1'b0, t0_r})) * 48'(lnq_r);
  assign den49 = $signed({2'b0, b100_r, 24'd0}) + $signed({prodt[47], prodt});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_sb_r <= '0;
      q_sb_r <= '0;
      e_sb_r <= '0;
      v_sb_r <= '0;
    end else begin
      d_sb_r <= lg_sb[ntcbt_pkg::FRAC_BITS];
      q_sb_r <= d_sb_r;
      e_sb_r <= {q_sb_r.vld, q_sb_r.cfg_bad, q_sb_r.zero,
                 den49[48] || (den49 == '0), q_sb_r.ovf};
      v_sb_r <= e_sb_r;
    end
  end

  always_ff @(posedge clk) begin
    d_r    <= $signed({2'b0, lb}) + $signed({2'b0, ls}) - $signed({2'b0, lf})
              - $signed({2'b0, lr});
    lnq_r  <= neg ? -$signed({1'b0, mag2}) : $signed({1'b0, mag2});
    den_r  <= den49[47:0];
    dvd_r  <= {1'b0, numc_r, 24'd0} + {17'd0, den_r[47:1]};
    vden_r <= den_r;
  end

  // Overflow check and divider initialisation.
  ntcbt_pkg::div_lane_t dv_lane [ntcbt_pkg::QUO_BITS+1];
  ntcbt_pkg::sband_t    dv_sb   [ntcbt_pkg::QUO_BITS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_sb[0] <= '0;
    end else begin
      dv_sb[0] <= {v_sb_r.vld, v_sb_r.cfg_bad, v_sb_r.zero, v_sb_r.np,
                   {5'd0, dvd_r} >= {vden_r, 21'd0}};
    end
  end

  always_ff @(posedge clk) begin
    dv_lane[0].den <= vden_r;
    dv_lane[0].rem <= {5'd0, dvd_r[63:21]};
    dv_lane[0].low <= dvd_r[20:0];
    dv_lane[0].q   <= '0;
  end

  for (genvar g = 0; g < ntcbt_pkg::QUO_BITS; g++) begin : g_div
    ntcbt_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .sb_i   (dv_sb[g]),
      .lane_i (dv_lane[g]),
      .sb_o   (dv_sb[g+1]),
      .lane_o (dv_lane[g+1])
    );
  end

  // Scale conversion and clamping.
  ntcbt_pkg::sband_t   f1_sb_r, f2_sb_r;
  logic [20:0]         qend, tk, tk1_r, tk2_r;
  logic [24:0]         x9_r;
  logic [52:0]         p5;
  logic [21:0]         f_r;
  logic signed [23:0]  tsel;
  logic                valid_r;
  logic signed [17:0]  temp_r, temp_nxt;
  ntcbt_pkg::status_t  status_r, status_nxt;

  assign qend = dv_lane[ntcbt_pkg::QUO_BITS].q;
  assign tk   = (dv_sb[ntcbt_pkg::QUO_BITS].ovf || qend > ntcbt_pkg::TK_CAP) ?
                ntcbt_pkg::TK_CAP : qend;
  assign p5   = 53'(x9_r) * 53'(ntcbt_pkg::DIV5_K);

  always_comb begin
    unique case (ntcbt_pkg::unit_t'(unit_r))
      ntcbt_pkg::UNIT_C: tsel = $signed({3'd0, tk2_r}) - 24'sd27315;
      ntcbt_pkg::UNIT_F: tsel = $signed({2'd0, f_r}) - 24'sd45967;
      default:           tsel = $signed({3'd0, tk2_r});
    endcase
    priority if (f2_sb_r.cfg_bad) begin
      temp_nxt   = '0;
      status_nxt = ntcbt_pkg::ST_SAT;
    end else if (f2_sb_r.zero) begin
      temp_nxt   = '0;
      status_nxt = ntcbt_pkg::ST_ZERO;
    end else if (f2_sb_r.np) begin
      temp_nxt   = 18'sd100000;
      status_nxt = ntcbt_pkg::ST_SAT;
    end else if (tsel > 24'sd100000) begin
      temp_nxt   = 18'sd100000;
      status_nxt = ntcbt_pkg::ST_SAT;
    end else if (tsel < -24'sd50000) begin
      temp_nxt   = -18'sd50000;
      status_nxt = ntcbt_pkg::ST_SAT;
    end else begin
      temp_nxt   = tsel[17:0];
      status_nxt = ntcbt_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_sb_r <= '0;
      f2_sb_r <= '0;
      valid_r <= 1'b0;
    end else begin
      f1_sb_r <= dv_sb[ntcbt_pkg::QUO_BITS];
      f2_sb_r <= f1_sb_r;
      valid_r <= f2_sb_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    tk1_r    <= tk;
    x9_r     <= 25'(tk) * 25'd9 + 25'd2;
    tk2_r    <= tk1_r;
    f_r      <= p5[51:30];
    temp_r   <= temp_nxt;
    status_r <= status_nxt;
  end

  assign out_valid             = valid_r;
  assign out_temperature_centi = temp_r;
  assign out_status            = status_r;

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without a matching request");

  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("request lost in the pipeline");

  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ntcbt_pkg::ST_ZERO) |-> out_temperature_centi == 18'sd0)
    else $error("zero sample gave a non-zero temperature");

  a_sat_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ntcbt_pkg::ST_SAT) |->
      (out_temperature_centi == 18'sd0 || out_temperature_centi == 18'sd100000 ||
       out_temperature_centi == -18'sd50000))
    else $error("saturated result not at a limit");

endmodule

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    logic signed [17:0]  temp;
    ntcbt_pkg::status_t  st;
  } reading_t;

  typedef struct {
    logic [9:0]          sample;
    bit                  typed;
    logic signed [17:0]  temp;
    ntcbt_pkg::status_t  st;
  } row_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [9:0]         in_adc_sample;
  logic               out_valid;
  logic signed [17:0] out_temperature_centi;
  logic [1:0]         out_status;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [23:0]        cfg_wdata;

  logic [15:0] beta_q;
  logic [15:0] t0_q;
  logic [23:0] r0_q;
  logic [23:0] rbal_q;
  logic [1:0]  unit_q;

  reading_t           readings_due[$];
  bit                 row_typed;
  logic signed [17:0] row_temp;
  ntcbt_pkg::status_t row_st;
  int                 mismatches;
  longint             cycles;

  ntc_beta_temperature dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_adc_sample         (in_adc_sample),
    .out_valid             (out_valid),
    .out_temperature_centi (out_temperature_centi),
    .out_status            (out_status),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint log2_fixed(input logic [63:0] x);
    int          k;
    logic [63:0] m;
    longint      r;
    k = 31;
    while (k > 0 && x[k] == 1'b0) k--;
    m = (x << (30 - k)) & 64'hFFFF_FFFF_FFFF;
    r = longint'(k) <<< 24;
    for (int i = 1; i <= 24; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        r = r + (longint'(1) <<< (24 - i));
      end
    end
    return r;
  endfunction

  function automatic reading_t predict_temperature(input logic [9:0] s);
    reading_t    res;
    longint      d;
    longint      lnq;
    longint      den;
    longint      t;
    logic [63:0] mag;
    logic [63:0] num;
    logic [63:0] tk;
    if (beta_q == 0 || t0_q == 0 || r0_q == 0 || rbal_q == 0) begin
      res.temp = '0;
      res.st   = ntcbt_pkg::ST_SAT;
      return res;
    end
    if (s == 0) begin
      res.temp = '0;
      res.st   = ntcbt_pkg::ST_ZERO;
      return res;
    end
    d = log2_fixed(64'(rbal_q)) + log2_fixed(64'(s)) - log2_fixed(64'd1024 - 64'(s))
        - log2_fixed(64'(r0_q));
    mag = (d < 0) ? 64'(-d) : 64'(d);
    mag = (mag * 64'd2977044472 + (64'd1 << 31)) >> 32;
    lnq = (d < 0) ? -longint'(mag) : longint'(mag);
    den = ((longint'(beta_q) * 100) <<< 24) + longint'(t0_q) * lnq;
    if (den <= 0) begin
      res.temp = 18'sd100000;
      res.st   = ntcbt_pkg::ST_SAT;
      return res;
    end
    num = (64'd100 * 64'(t0_q) * 64'(beta_q)) << 24;
    tk  = (num + 64'(den) / 2) / 64'(den);
    if (tk > 64'd2000000) tk = 64'd2000000;
    if (unit_q == ntcbt_pkg::UNIT_C) t = longint'(tk) - 27315;
    else if (unit_q == ntcbt_pkg::UNIT_F) t = longint'((tk * 9 + 2) / 5) - 45967;
    else t = longint'(tk);
    if (t > 100000) begin
      res.temp = 18'sd100000;
      res.st   = ntcbt_pkg::ST_SAT;
    end else if (t < -50000) begin
      res.temp = -18'sd50000;
      res.st   = ntcbt_pkg::ST_SAT;
    end else begin
      res.temp = 18'(t);
      res.st   = ntcbt_pkg::ST_OK;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    reading_t due;
    reading_t got;
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("[ntc_beta_temperature] ERROR");
      $finish;
    end
    if (rst_n) begin
      if (start && !busy) begin
        if (row_typed) begin
          due.temp = row_temp;
          due.st   = row_st;
        end else begin
          due = predict_temperature(in_adc_sample);
        end
        readings_due.push_back(due);
      end
      if (out_valid) begin
        got.temp = out_temperature_centi;
        got.st   = ntcbt_pkg::status_t'(out_status);
        if (readings_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: temp %0d status %0d", got.temp, got.st);
        end else begin
          due = readings_due.pop_front();
          if (got.temp !== due.temp || got.st !== due.st) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected temp %0d status %0d, got temp %0d status %0d",
                       due.temp, due.st, got.temp, got.st);
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      ntcbt_pkg::CFG_BETA: beta_q = value[15:0];
      ntcbt_pkg::CFG_T0:   t0_q   = value[15:0];
      ntcbt_pkg::CFG_R0:   r0_q   = value;
      ntcbt_pkg::CFG_RBAL: rbal_q = value;
      ntcbt_pkg::CFG_UNIT: unit_q = value[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic send_sample(input logic [9:0] s, input bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
    end
    @(negedge clk);
    start         <= 1'b1;
    in_adc_sample <= s;
    do @(posedge clk); while (busy);
  endtask

  task automatic stop_requests;
    @(negedge clk);
    start     <= 1'b0;
    row_typed = 1'b0;
  endtask

  task automatic run_setting(input logic [15:0] b, input logic [15:0] t0,
                             input logic [23:0] r0, input logic [23:0] rb,
                             input logic [1:0] u, input int n, input bit gaps);
    logic [23:0] noise;
    drain();
    noise = 24'($urandom);
    write_reg(ntcbt_pkg::CFG_BETA, {noise[23:16], b});
    write_reg(ntcbt_pkg::CFG_T0, {noise[15:8], t0});
    write_reg(ntcbt_pkg::CFG_R0, r0);
    write_reg(ntcbt_pkg::CFG_RBAL, rb);
    write_reg(ntcbt_pkg::CFG_UNIT, {noise[21:0], u});
    if ($urandom_range(0, 1) == 0)
      write_reg(3'($urandom_range(5, 7)), 24'($urandom));
    for (int i = 0; i < n; i++) send_sample(10'($urandom_range(0, 1023)), gaps);
    stop_requests();
  endtask

  row_t rows[$];

  initial begin
    row_t r;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_adc_sample = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    row_typed     = 1'b0;
    row_temp      = '0;
    row_st        = ntcbt_pkg::ST_OK;
    mismatches    = 0;
    cycles        = 0;
    beta_q        = ntcbt_pkg::BETA_RST;
    t0_q          = ntcbt_pkg::T0_RST;
    r0_q          = ntcbt_pkg::R0_RST;
    rbal_q        = ntcbt_pkg::RBAL_RST;
    unit_q        = ntcbt_pkg::UNIT_C;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // With the reset setting a mid-scale reading gives R equal to R0, hence T0.
    rows.push_back('{10'd0, 1'b1, 18'sd0, ntcbt_pkg::ST_ZERO});
    rows.push_back('{10'd512, 1'b1, 18'sd2500, ntcbt_pkg::ST_OK});
    rows.push_back('{10'd1, 1'b0, 18'sd0, ntcbt_pkg::ST_OK});
    rows.push_back('{10'd2, 1'b0, 18'sd0, ntcbt_pkg::ST_OK});
    rows.push_back('{10'd511, 1'b0, 18'sd0, ntcbt_pkg::ST_OK});
    rows.push_back('{10'd513, 1'b0, 18'sd0, ntcbt_pkg::ST_OK});
    rows.push_back('{10'd1023, 1'b0, 18'sd0, ntcbt_pkg::ST_OK});
    rows.push_back('{10'd1022, 1'b0, 18'sd0, ntcbt_pkg::ST_OK});
    rows.push_back('{10'd341, 1'b0, 18'sd0, ntcbt_pkg::ST_OK});
    rows.push_back('{10'd682, 1'b0, 18'sd0, ntcbt_pkg::ST_OK});
    rows.push_back('{10'd256, 1'b0, 18'sd0, ntcbt_pkg::ST_OK});
    rows.push_back('{10'd768, 1'b0, 18'sd0, ntcbt_pkg::ST_OK});
    rows.push_back('{10'd100, 1'b0, 18'sd0, ntcbt_pkg::ST_OK});
    rows.push_back('{10'd900, 1'b0, 18'sd0, ntcbt_pkg::ST_OK});
    rows.push_back('{10'h155, 1'b0, 18'sd0, ntcbt_pkg::ST_OK});
    rows.push_back('{10'h2AA, 1'b0, 18'sd0, ntcbt_pkg::ST_OK});
    foreach (rows[i]) begin
      r = rows[i];
      @(negedge clk);
      start         <= 1'b1;
      in_adc_sample <= r.sample;
      row_typed     = r.typed;
      row_temp      = r.temp;
      row_st        = r.st;
      do @(posedge clk); while (busy);
    end
    stop_requests();

    run_setting(16'd4250, 16'd29815, 24'd100000, 24'd100000, ntcbt_pkg::UNIT_K, 40, 1'b1);
    run_setting(16'd4250, 16'd29815, 24'd100000, 24'd100000, ntcbt_pkg::UNIT_F, 40, 1'b1);
    run_setting(16'd3950, 16'd29815, 24'd10000, 24'd10000, 2'd3, 40, 1'b1);
    run_setting(16'd1, 16'd29815, 24'd100000, 24'd100000, ntcbt_pkg::UNIT_C, 40, 1'b1);
    run_setting(16'd65535, 16'd65535, 24'd100000, 24'd100000, ntcbt_pkg::UNIT_K, 40, 1'b1);
    run_setting(16'd4250, 16'd1, 24'd100000, 24'd100000, ntcbt_pkg::UNIT_F, 40, 1'b1);
    run_setting(16'd4250, 16'd29815, 24'd1, 24'd16777215, ntcbt_pkg::UNIT_C, 40, 1'b1);
    run_setting(16'd4250, 16'd29815, 24'd16777215, 24'd1, ntcbt_pkg::UNIT_K, 40, 1'b1);
    run_setting(16'd0, 16'd29815, 24'd100000, 24'd100000, ntcbt_pkg::UNIT_C, 20, 1'b1);
    run_setting(16'd4250, 16'd0, 24'd100000, 24'd100000, ntcbt_pkg::UNIT_C, 20, 1'b1);
    run_setting(16'd4250, 16'd29815, 24'd0, 24'd100000, ntcbt_pkg::UNIT_F, 20, 1'b1);
    run_setting(16'd4250, 16'd29815, 24'd100000, 24'd0, ntcbt_pkg::UNIT_K, 20, 1'b1);
    for (int p = 0; p < 8; p++)
      run_setting(16'($urandom_range(2000, 6000)), 16'($urandom_range(27315, 32315)),
                  24'($urandom_range(1000, 1000000)), 24'($urandom_range(1000, 1000000)),
                  2'($urandom_range(0, 3)), 100, 1'b1);
    run_setting(16'd4250, 16'd29815, 24'd100000, 24'd100000, ntcbt_pkg::UNIT_C, 120, 1'b0);

    drain();
    if (mismatches == 0) begin
      $display("[ntc_beta_temperature] OK");
    end else begin
      $display("[ntc_beta_temperature] ERROR");
    end
    $finish;
  end

endmodule
